>>> src/lfbs_pkg.sv
// shared types, constants and the word count table of the layer fetch sequencer
package lfbs_pkg;

  localparam int MAX_BURST   = 256;
  localparam int LAYER_COUNT = 9;

  localparam int LAYER_W = 4;
  localparam int WORDS_W = 26;
  localparam int BURST_W = 9;
  localparam int BEATS_W = 9;
  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 32;
  localparam int LEN_W   = 8;
  localparam int FLIT_W  = 34;

  localparam logic [LAYER_W-1:0] BEFORE_FIRST = 4'hF;
  localparam logic [3:0]         SRC_ID       = 4'hF;
  localparam logic [BEATS_W-1:0] BEATS_MAX    = 9'd511;

  // result kinds
  localparam logic [1:0] KIND_ANNOUNCE = 2'd0;
  localparam logic [1:0] KIND_REQUEST  = 2'd1;
  localparam logic [1:0] KIND_FLIT     = 2'd2;

  // flit type codes
  localparam logic [1:0] FLIT_BODY   = 2'd0;
  localparam logic [1:0] FLIT_TAIL   = 2'd1;
  localparam logic [1:0] FLIT_HEADER = 2'd2;

  // data type codes in header and tail
  localparam logic [1:0] DT_INPUT  = 2'd0;
  localparam logic [1:0] DT_WEIGHT = 2'd1;
  localparam logic [1:0] DT_BIAS   = 2'd2;

  // work handed from front to back
  typedef enum logic [2:0] {
    OP_START_BURST,
    OP_START_EMPTY,
    OP_BEAT,
    OP_BEAT_REQ,
    OP_BEAT_TAIL
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [LAYER_W-1:0] layer;
    logic               bias;
    logic [DATA_W-1:0]  data;
    logic               flag;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
  } cmd_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // words to fetch for one transfer
  function automatic logic [WORDS_W-1:0] word_count(input logic [LAYER_W-1:0] layer,
                                                     input logic bias);
    logic [WORDS_W-1:0] w;
    w = '0;
    case (layer)
      4'd0: w = bias ? 26'd0    : 26'd150528;
      4'd1: w = bias ? 26'd64   : 26'd23232;
      4'd2: w = bias ? 26'd192  : 26'd307200;
      4'd3: w = bias ? 26'd384  : 26'd663552;
      4'd4: w = bias ? 26'd256  : 26'd884736;
      4'd5: w = bias ? 26'd256  : 26'd589824;
      4'd6: w = bias ? 26'd4096 : 26'd37748736;
      4'd7: w = bias ? 26'd4096 : 26'd16777216;
      4'd8: w = bias ? 26'd1000 : 26'd4096000;
      default: w = '0;
    endcase
    return w;
  endfunction

  // size of the next burst
  function automatic logic [BURST_W-1:0] burst_size(input logic [WORDS_W-1:0] rem);
    logic [BURST_W-1:0] b;
    if (rem < WORDS_W'(MAX_BURST)) begin
      b = BURST_W'(rem);
    end else begin
      b = BURST_W'(MAX_BURST);
    end
    return b;
  endfunction

endpackage

>>> src/lfbs_front.sv
// front part: accepts items, tracks transfer state and issues commands
module lfbs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                func,
  input  logic [31:0]         beat_data,
  input  logic                beat_last,
  input  logic [1:0]          beat_resp,
  output logic                cmd_push,
  output lfbs_pkg::cmd_t      cmd
);

  logic [lfbs_pkg::LAYER_W-1:0] layer_r, layer_nxt;
  logic                         bias_r, bias_nxt;
  logic                         busy_r, busy_nxt;
  logic [lfbs_pkg::WORDS_W-1:0] rem_r, rem_nxt;
  logic [lfbs_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [lfbs_pkg::BURST_W-1:0] burst_r, burst_nxt;
  logic [lfbs_pkg::BEATS_W-1:0] beats_r, beats_nxt;

  logic [lfbs_pkg::LAYER_W-1:0] st_layer;
  logic                         st_bias;
  logic [lfbs_pkg::WORDS_W-1:0] st_words;
  logic [lfbs_pkg::BURST_W-1:0] st_burst;
  logic [lfbs_pkg::BEATS_W-1:0] bt_beats;
  logic [lfbs_pkg::WORDS_W-1:0] bt_rem;
  logic [lfbs_pkg::ADDR_W-1:0]  bt_addr;
  logic [lfbs_pkg::BURST_W-1:0] bt_burst;

  // next state and command
  always_comb begin
    layer_nxt = layer_r;
    bias_nxt  = bias_r;
    busy_nxt  = busy_r;
    rem_nxt   = rem_r;
    addr_nxt  = addr_r;
    burst_nxt = burst_r;
    beats_nxt = beats_r;
    cmd_push  = 1'b0;
    cmd.op    = lfbs_pkg::OP_BEAT;
    cmd.layer = layer_r;
    cmd.bias  = bias_r;
    cmd.data  = beat_data;
    cmd.flag  = 1'b0;
    cmd.addr  = '0;
    cmd.len   = '0;

    // start path
    if (!bias_r && layer_r != lfbs_pkg::BEFORE_FIRST && layer_r != '0) begin
      st_layer = layer_r;
      st_bias  = 1'b1;
    end else begin
      st_layer = layer_r + 1'b1;
      st_bias  = 1'b0;
    end
    st_words = lfbs_pkg::word_count(st_layer, st_bias);
    st_burst = lfbs_pkg::burst_size(st_words);

    // beat path
    bt_beats = (beats_r < lfbs_pkg::BEATS_MAX) ? beats_r + 1'b1 : beats_r;
    bt_rem   = (rem_r >= lfbs_pkg::WORDS_W'(burst_r)) ?
               rem_r - lfbs_pkg::WORDS_W'(burst_r) : '0;
    bt_addr  = addr_r + lfbs_pkg::ADDR_W'({burst_r, 2'b00});
    bt_burst = lfbs_pkg::burst_size(bt_rem);

    if (accept) begin
      if (!func) begin
        if (!busy_r && (layer_r == lfbs_pkg::BEFORE_FIRST ||
                        layer_r < lfbs_pkg::LAYER_W'(lfbs_pkg::LAYER_COUNT))) begin
          layer_nxt = st_layer;
          bias_nxt  = st_bias;
          if (st_layer < lfbs_pkg::LAYER_W'(lfbs_pkg::LAYER_COUNT)) begin
            rem_nxt   = st_words;
            addr_nxt  = '0;
            beats_nxt = '0;
            cmd_push  = 1'b1;
            cmd.layer = st_layer;
            cmd.bias  = st_bias;
            if (st_words != '0) begin
              burst_nxt = st_burst;
              busy_nxt  = 1'b1;
              cmd.op    = lfbs_pkg::OP_START_BURST;
              cmd.len   = lfbs_pkg::LEN_W'(st_burst - 1'b1);
            end else begin
              burst_nxt = '0;
              cmd.op    = lfbs_pkg::OP_START_EMPTY;
            end
          end
        end
      end else if (busy_r) begin
        cmd_push = 1'b1;
        if (!beat_last) begin
          beats_nxt = bt_beats;
          cmd.op    = lfbs_pkg::OP_BEAT;
          cmd.flag  = (beat_resp != 2'd0);
        end else begin
          cmd.flag  = (bt_beats != burst_r);
          rem_nxt   = bt_rem;
          addr_nxt  = bt_addr;
          beats_nxt = '0;
          if (bt_rem != '0) begin
            burst_nxt = bt_burst;
            cmd.op    = lfbs_pkg::OP_BEAT_REQ;
            cmd.addr  = bt_addr;
            cmd.len   = lfbs_pkg::LEN_W'(bt_burst - 1'b1);
          end else begin
            busy_nxt = 1'b0;
            cmd.op   = lfbs_pkg::OP_BEAT_TAIL;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_r <= lfbs_pkg::BEFORE_FIRST;
      bias_r  <= 1'b0;
      busy_r  <= 1'b0;
      rem_r   <= '0;
      addr_r  <= '0;
      burst_r <= '0;
      beats_r <= '0;
    end else begin
      layer_r <= layer_nxt;
      bias_r  <= bias_nxt;
      busy_r  <= busy_nxt;
      rem_r   <= rem_nxt;
      addr_r  <= addr_nxt;
      burst_r <= burst_nxt;
      beats_r <= beats_nxt;
    end
  end

endmodule

>>> src/lfbs_cmd_fifo.sv
// short command queue between front and back
module lfbs_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lfbs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lfbs_pkg::cmd_t pop_cmd
);

  lfbs_pkg::cmd_t               mem_r [lfbs_pkg::FIFO_DEPTH];
  logic [lfbs_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [lfbs_pkg::FIFO_AW:0]   count_r;
  logic                         do_push, do_pop;

  // status
  assign full    = (count_r == (lfbs_pkg::FIFO_AW+1)'(lfbs_pkg::FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> src/lfbs_back.sv
// back part: expands each command into its result items
module lfbs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  lfbs_pkg::cmd_t      cmd_in,
  output logic                cmd_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [1:0]          out_kind,
  output logic [3:0]          out_layer,
  output logic                out_layer_type,
  output logic [31:0]         out_req_address,
  output logic [7:0]          out_req_length,
  output logic [33:0]         out_flit,
  output logic                out_resp_error,
  output logic                out_count_mismatch,
  output logic                out_last
);

  logic           cur_valid_r, cur_valid_nxt;
  lfbs_pkg::cmd_t cur_r, cur_nxt;
  logic [1:0]     step_r, step_nxt;
  logic [1:0]     final_step;
  logic           done;
  logic [1:0]     dtype;
  logic [33:0]    hdr_flit, tail_flit, body_flit;

  // steps per command
  always_comb begin
    case (cur_r.op)
      lfbs_pkg::OP_START_BURST: final_step = 2'd2;
      lfbs_pkg::OP_START_EMPTY: final_step = 2'd2;
      lfbs_pkg::OP_BEAT:        final_step = 2'd0;
      lfbs_pkg::OP_BEAT_REQ:    final_step = 2'd1;
      lfbs_pkg::OP_BEAT_TAIL:   final_step = 2'd1;
      default:                  final_step = 2'd0;
    endcase
  end

  // sequencing: load the next command when the current one is drained
  assign done    = !cur_valid_r || (out_pop && step_r == final_step);
  assign cmd_pop = done && !cmd_empty;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    if (done) begin
      cur_valid_nxt = !cmd_empty;
      cur_nxt       = cmd_in;
      step_nxt      = 2'd0;
    end else if (out_pop) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // flit framing
  always_comb begin
    if (cur_r.layer == '0) begin
      dtype = lfbs_pkg::DT_INPUT;
    end else if (cur_r.bias) begin
      dtype = lfbs_pkg::DT_BIAS;
    end else begin
      dtype = lfbs_pkg::DT_WEIGHT;
    end
  end

  assign hdr_flit  = {lfbs_pkg::FLIT_HEADER, lfbs_pkg::SRC_ID, cur_r.layer, dtype, 22'd0};
  assign tail_flit = {lfbs_pkg::FLIT_TAIL, lfbs_pkg::SRC_ID, cur_r.layer, dtype, 22'd0};
  assign body_flit = {lfbs_pkg::FLIT_BODY, cur_r.data};

  // result fields
  assign out_empty      = !cur_valid_r;
  assign out_layer      = cur_r.layer;
  assign out_layer_type = cur_r.bias;
  assign out_last       = (step_r == final_step);

  always_comb begin
    out_kind           = lfbs_pkg::KIND_FLIT;
    out_req_address    = '0;
    out_req_length     = '0;
    out_flit           = '0;
    out_resp_error     = 1'b0;
    out_count_mismatch = 1'b0;
    case (cur_r.op)
      lfbs_pkg::OP_START_BURST: begin
        if (step_r == 2'd0) begin
          out_kind = lfbs_pkg::KIND_ANNOUNCE;
        end else if (step_r == 2'd1) begin
          out_kind       = lfbs_pkg::KIND_REQUEST;
          out_req_length = cur_r.len;
        end else begin
          out_flit = hdr_flit;
        end
      end
      lfbs_pkg::OP_START_EMPTY: begin
        if (step_r == 2'd0) begin
          out_kind = lfbs_pkg::KIND_ANNOUNCE;
        end else if (step_r == 2'd1) begin
          out_flit = hdr_flit;
        end else begin
          out_flit = tail_flit;
        end
      end
      lfbs_pkg::OP_BEAT: begin
        out_flit       = body_flit;
        out_resp_error = cur_r.flag;
      end
      lfbs_pkg::OP_BEAT_REQ: begin
        if (step_r == 2'd0) begin
          out_flit           = body_flit;
          out_count_mismatch = cur_r.flag;
        end else begin
          out_kind        = lfbs_pkg::KIND_REQUEST;
          out_req_address = cur_r.addr;
          out_req_length  = cur_r.len;
        end
      end
      lfbs_pkg::OP_BEAT_TAIL: begin
        if (step_r == 2'd0) begin
          out_flit           = body_flit;
          out_count_mismatch = cur_r.flag;
        end else begin
          out_flit = tail_flit;
        end
      end
      default: begin
        out_kind = lfbs_pkg::KIND_FLIT;
      end
    endcase
  end

endmodule

>>> src/layer_fetch_burst_flit_sequencer.sv
// top level of the layer fetch burst and flit sequencer
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------------
//   input    | in_push/in_full  | in_func, in_beat_data, in_beat_last, in_beat_resp
//   result   | out_empty/out_pop| out_kind, out_layer, out_layer_type, out_req_*,
//            |                  | out_flit, out_resp_error, out_count_mismatch, out_last
//
// an item is taken every cycle while the four-entry command queue has room; the
// front updates transfer state in the cycle of acceptance
// the back hands out one result per cycle while popped: a beat gives one or two,
// a start three, none if ignored, so sustained input rate is set by these counts
// with the back idle, the first result shows once the item is queued and loaded
// synchronous active-low reset returns to the state before the first transfer
module layer_fetch_burst_flit_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [31:0] in_beat_data,
  input  logic        in_beat_last,
  input  logic [1:0]  in_beat_resp,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_layer,
  output logic        out_layer_type,
  output logic [31:0] out_req_address,
  output logic [7:0]  out_req_length,
  output logic [33:0] out_flit,
  output logic        out_resp_error,
  output logic        out_count_mismatch,
  output logic        out_last
);

  logic           accept;
  logic           cmd_push;
  lfbs_pkg::cmd_t cmd_front;
  logic           cmd_empty;
  logic           cmd_pop;
  lfbs_pkg::cmd_t cmd_back;

  assign accept = in_push && !in_full;

  // front: classify items and keep transfer state
  lfbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_func),
    .beat_data (in_beat_data),
    .beat_last (in_beat_last),
    .beat_resp (in_beat_resp),
    .cmd_push  (cmd_push),
    .cmd       (cmd_front)
  );

  // queue between the parts
  lfbs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_front),
    .full     (in_full),
    .pop      (cmd_pop),
    .empty    (cmd_empty),
    .pop_cmd  (cmd_back)
  );

  // back: produce result items
  lfbs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_empty          (cmd_empty),
    .cmd_in             (cmd_back),
    .cmd_pop            (cmd_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_layer          (out_layer),
    .out_layer_type     (out_layer_type),
    .out_req_address    (out_req_address),
    .out_req_length     (out_req_length),
    .out_flit           (out_flit),
    .out_resp_error     (out_resp_error),
    .out_count_mismatch (out_count_mismatch),
    .out_last           (out_last)
  );

endmodule
